// File: hdl/awsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awsp_pkg
// Shared widths, codes and threshold tables of the segment packer.
// ----------------------------------------------------------------------------
package awsp_pkg;

  localparam int SAMPLE_W = 31;
  localparam int SIZE_W   = 15;
  localparam int HDR_BITS = 12;
  localparam int MAX_RUN  = 127;
  localparam int ACC_W    = 40;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Largest run that a width step of d bits may keep before the tail saves
  // more than the cut limit, that is floor(24 / d).
  localparam logic [7:0] THR24 [32] = '{
    8'd255, 8'd24, 8'd12, 8'd8, 8'd6, 8'd4, 8'd4, 8'd3,
    8'd3,   8'd2,  8'd2,  8'd2, 8'd2, 8'd1, 8'd1, 8'd1,
    8'd1,   8'd1,  8'd1,  8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1,   8'd0,  8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // Largest count that may widen by d bits, that is floor(12 / d).
  localparam logic [7:0] THR12 [32] = '{
    8'd255, 8'd12, 8'd6, 8'd4, 8'd3, 8'd2, 8'd2, 8'd1,
    8'd1,   8'd1,  8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
    8'd0,   8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0,   8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

endpackage

// File: hdl/awsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awsp_in_if / awsp_out_if
// Valid/ready channels for samples and read commands in, packed bytes out.
// ----------------------------------------------------------------------------
interface awsp_in_if;
  import awsp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  modport source (output valid, mode, sample, last, input ready);
  modport sink (input valid, mode, sample, last, output ready);
endinterface

interface awsp_out_if;
  import awsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        packed_byte;
  logic              byte_last;
  logic [SIZE_W-1:0] packed_size;
  modport source (output valid, packed_byte, byte_last, packed_size, input ready);
  modport sink (input valid, packed_byte, byte_last, packed_size, output ready);
endinterface

// File: hdl/adaptive_width_segment_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_width_segment_packer_top
// Loads a block of samples, packs it into width-adaptive segments and reads
// the packed bytes out in order.
//
//   channel  direction  payload
//   in_ch    sink       mode, sample, last
//   out_ch   source     packed_byte, byte_last, packed_size
//
// A sample is stored as it is taken, while the sample RAM has room. The
// flagged last sample starts packing: segment analysis fetches each
// sample, checks each later one of a segment for a widening and steps the
// run lengths, emission writes headers, samples and bytes; no transaction
// is taken meanwhile. Reads pass the packed RAM and output registers.
// Synchronous reset leaves no packed block, so reads give no result.
// A read waits while the output register holds an untaken byte.
// ----------------------------------------------------------------------------
module adaptive_width_segment_packer_top #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 31
) (
  input  logic clk,
  input  logic rst_n,
  awsp_in_if.sink    in_ch,
  awsp_out_if.source out_ch
);
  import awsp_pkg::*;

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int PACK_BYTES = (MAX_SAMPLES * (SAMPLE_BITS + 12) + 7) / 8;
  localparam int PAW = $clog2(PACK_BYTES);
  localparam int SZW = $clog2(PACK_BYTES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_PACK, ST_READ} tstate_t;

  tstate_t        st_r;
  logic [CW-1:0]  cnt_r;
  logic [SZW-1:0] rp_r, size_r;
  logic           out_vld_r, out_last_r;
  logic [7:0]     out_byte_r;
  logic [SZW-1:0] out_size_r;

  logic                   acc, load, rd_cmd, s_we, start, p_re, p_we, p_done;
  logic [CW-1:0]          total;
  logic [SAW-1:0]         s_raddr;
  logic [SAMPLE_BITS-1:0] s_rdata;
  logic [PAW-1:0]         p_waddr;
  logic [7:0]             p_wdata, p_rdata;
  logic [SZW-1:0]         p_size;
  logic [SZW+SIZE_W-1:0]  size_ext;

  assign in_ch.ready = (st_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign acc    = in_ch.valid && in_ch.ready;
  assign load   = acc && (in_ch.mode == MODE_LOAD);
  assign rd_cmd = acc && (in_ch.mode == MODE_READ) && (rp_r < size_r);
  assign s_we   = load && (cnt_r < CW'(MAX_SAMPLES));
  assign start  = load && in_ch.last;
  assign total  = s_we ? (cnt_r + CW'(1)) : cnt_r;

  assign size_ext           = {{SIZE_W{1'b0}}, out_size_r};
  assign out_ch.valid       = out_vld_r;
  assign out_ch.packed_byte = out_byte_r;
  assign out_ch.byte_last   = out_last_r;
  assign out_ch.packed_size = size_ext[SIZE_W-1:0];

  awsp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (cnt_r[SAW-1:0]),
    .wdata (in_ch.sample[SAMPLE_BITS-1:0]),
    .re    (p_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  awsp_ram #(.WIDTH(8), .DEPTH(PACK_BYTES)) u_packed_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (rd_cmd),
    .raddr (rp_r[PAW-1:0]),
    .rdata (p_rdata)
  );

  awsp_packer #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .total   (total),
    .rd_en   (p_re),
    .rd_addr (s_raddr),
    .rd_data (s_rdata),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .size    (p_size),
    .done    (p_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      rp_r      <= '0;
      size_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_ch.ready && (st_r != ST_READ)) out_vld_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (s_we) cnt_r <= cnt_r + CW'(1);
          if (start) begin
            st_r <= ST_PACK;
          end else if (rd_cmd) begin
            st_r <= ST_READ;
          end
        end
        ST_PACK: begin
          if (p_done) begin
            size_r <= p_size;
            rp_r   <= '0;
            cnt_r  <= '0;
            st_r   <= ST_IDLE;
          end
        end
        ST_READ: begin
          out_vld_r  <= 1'b1;
          out_byte_r <= p_rdata;
          out_last_r <= (rp_r + SZW'(1)) == size_r;
          out_size_r <= size_r;
          rp_r       <= rp_r + SZW'(1);
          st_r       <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/awsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module awsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/awsp_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awsp_packer
// Splits the stored block into segments and writes the packed bytes.
// ----------------------------------------------------------------------------
module awsp_packer #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 31,
  localparam int CW  = $clog2(MAX_SAMPLES + 1),
  localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int PACK_BYTES = (MAX_SAMPLES * (SAMPLE_BITS + 12) + 7) / 8,
  localparam int PAW = $clog2(PACK_BYTES),
  localparam int SZW = $clog2(PACK_BYTES + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CW-1:0]          total,
  output logic                   rd_en,
  output logic [SAW-1:0]         rd_addr,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic                   wr_en,
  output logic [PAW-1:0]         wr_addr,
  output logic [7:0]             wr_data,
  output logic [SZW-1:0]         size,
  output logic                   done
);
  import awsp_pkg::*;

  localparam int SUMW = CW + 8;

  typedef enum logic [3:0] {
    P_IDLE, P_FETCH, P_PREC, P_WIDEN, P_STEP, P_HDR, P_DRAIN, P_APP, P_FLUSH
  } pstate_t;

  pstate_t          st_r, st_nxt;
  logic [CW-1:0]    seg_r, seg_nxt, rem_r, rem_nxt;
  logic [6:0]       cnt_r, cnt_nxt, k_r, k_nxt;
  logic [4:0]       wid_r, wid_nxt, p_r, p_nxt;
  logic             first_r, first_nxt, done_r, done_nxt;
  logic [6:0]       runs_r [32];
  logic [6:0]       runs_nxt [32];
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [5:0]       nb_r, nb_nxt;
  logic [SZW-1:0]   wa_r, wa_nxt;

  logic [7:0]       nr [32];
  logic [4:0]       dd [32];
  logic [31:0]      exc;
  logic             hit;
  logic [4:0]       fi, dw;
  logic [7:0]       cnt1, nrf, cntc;
  logic [SUMW-1:0]  sum;
  logic [ACC_W-1:0] app_v, app_acc;
  logic [5:0]       app_w, sh;

  function automatic logic [4:0] prec(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS-1:0] u;
    logic [4:0] n;
    u = raw[SAMPLE_BITS-1] ? ~raw : raw;
    n = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (u[i]) n = 5'(i + 1);
    end
    prec = (raw == '0) ? 5'd0 : n + 5'd1;
  endfunction

  assign sum     = SUMW'(seg_r) + SUMW'((st_r == P_DRAIN) ? k_r : cnt_r);
  assign rd_addr = sum[SAW-1:0];
  assign rd_en   = (st_r == P_FETCH) || (st_r == P_DRAIN);
  assign wr_en   = ((st_r == P_DRAIN) && (nb_r >= 6'd8)) || ((st_r == P_FLUSH) && (nb_r != 6'd0));
  assign wr_addr = wa_r[PAW-1:0];
  assign wr_data = acc_r[ACC_W-1 -: 8];
  assign size    = wa_r;
  assign done    = done_r;

  // Run lengths of every narrower width, evaluated in parallel.
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      dd[j]  = wid_r - 5'(j);
      nr[j]  = (p_r <= 5'(j)) ? ({1'b0, runs_r[j]} + 8'd1) : 8'd0;
      exc[j] = (5'(j) < wid_r) && (p_r <= 5'(j)) && (nr[j] > THR24[dd[j]]);
    end
    hit = |exc;
    fi  = '0;
    for (int j = 31; j >= 0; j--) begin
      if (exc[j]) fi = 5'(j);
    end
    cnt1 = {1'b0, cnt_r} + 8'd1;
    nrf  = nr[fi];
    cntc = (nrf < cnt1) ? (cnt1 - nrf) : cnt1;
    dw   = p_r - wid_r;
  end

  always_comb begin
    if (st_r == P_HDR) begin
      app_v = ACC_W'({cnt_r, wid_r});
      app_w = 6'(HDR_BITS);
    end else begin
      app_v = ACC_W'(rd_data);
      app_w = {1'b0, wid_r};
    end
    sh      = 6'(ACC_W) - nb_r - app_w;
    app_acc = acc_r | ((app_v & ((ACC_W'(1) << app_w) - ACC_W'(1))) << sh);
  end

  always_comb begin
    st_nxt    = st_r;
    seg_nxt   = seg_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    wid_nxt   = wid_r;
    p_nxt     = p_r;
    first_nxt = first_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    nb_nxt    = nb_r;
    wa_nxt    = wa_r;
    runs_nxt  = runs_r;
    case (st_r)
      P_IDLE: begin
        if (start) begin
          seg_nxt   = '0;
          rem_nxt   = total;
          cnt_nxt   = '0;
          first_nxt = 1'b1;
          acc_nxt   = '0;
          nb_nxt    = '0;
          wa_nxt    = '0;
          st_nxt    = P_FETCH;
        end
      end
      P_FETCH: st_nxt = P_PREC;
      P_PREC: begin
        p_nxt = prec(rd_data);
        if (first_r) begin
          wid_nxt   = prec(rd_data);
          first_nxt = 1'b0;
          for (int j = 0; j < 32; j++) runs_nxt[j] = '0;
          st_nxt    = P_STEP;
        end else begin
          st_nxt = P_WIDEN;
        end
      end
      P_WIDEN: begin
        st_nxt = P_STEP;
        if (p_r > wid_r) begin
          if ({1'b0, cnt_r} > THR12[dw]) begin
            st_nxt = P_HDR;
          end else begin
            for (int j = 0; j < 32; j++) begin
              if ((5'(j) >= wid_r) && (5'(j) < p_r)) runs_nxt[j] = cnt_r;
            end
            wid_nxt = p_r;
          end
        end
      end
      P_STEP: begin
        for (int j = 0; j < 32; j++) begin
          if ((5'(j) < wid_r) && (!hit || (5'(j) <= fi))) runs_nxt[j] = nr[j][6:0];
        end
        if (hit) begin
          cnt_nxt = cntc[6:0];
          st_nxt  = P_HDR;
        end else begin
          cnt_nxt = cnt1[6:0];
          if ((SUMW'(cnt1) < SUMW'(rem_r)) && (cnt1 < 8'(MAX_RUN))) begin
            st_nxt = P_FETCH;
          end else begin
            st_nxt = P_HDR;
          end
        end
      end
      P_HDR: begin
        acc_nxt = app_acc;
        nb_nxt  = nb_r + app_w;
        k_nxt   = '0;
        st_nxt  = P_DRAIN;
      end
      P_DRAIN: begin
        if (nb_r >= 6'd8) begin
          acc_nxt = acc_r << 8;
          nb_nxt  = nb_r - 6'd8;
          wa_nxt  = wa_r + SZW'(1);
        end else if (k_r < cnt_r) begin
          st_nxt = P_APP;
        end else begin
          seg_nxt = seg_r + CW'(cnt_r);
          rem_nxt = rem_r - CW'(cnt_r);
          if (rem_r == CW'(cnt_r)) begin
            st_nxt = P_FLUSH;
          end else begin
            cnt_nxt   = '0;
            first_nxt = 1'b1;
            st_nxt    = P_FETCH;
          end
        end
      end
      P_APP: begin
        acc_nxt = app_acc;
        nb_nxt  = nb_r + app_w;
        k_nxt   = k_r + 7'd1;
        st_nxt  = P_DRAIN;
      end
      P_FLUSH: begin
        if (nb_r != 6'd0) wa_nxt = wa_r + SZW'(1);
        done_nxt = 1'b1;
        st_nxt   = P_IDLE;
      end
      default: st_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    seg_r   <= seg_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    wid_r   <= wid_nxt;
    p_r     <= p_nxt;
    first_r <= first_nxt;
    acc_r   <= acc_nxt;
    nb_r    <= nb_nxt;
    wa_r    <= wa_nxt;
    runs_r  <= runs_nxt;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive-width segment packer. Sample blocks
// with varied precision are loaded and packed. The packed bytes are then read
// back, including reads past the end and reads while a block is loading. Each
// byte, its last flag and the packed size are compared with a bit-exact
// software packer held in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import awsp_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int PACK_BYTES  = 22016;
  localparam int IDLE_LIMIT  = 400000;

  typedef struct {
    logic [7:0]        packed_byte;
    logic              byte_last;
    logic [SIZE_W-1:0] packed_size;
  } byte_rec_t;

  class packer_scoreboard;
    bit [SAMPLE_W-1:0] samples [STORE_DEPTH];
    bit [7:0]          stream [PACK_BYTES];
    int                fill;
    int                seg_base;
    int                bit_len;
    int                rd_ptr;
    int                errors;
    int                checked;
    int                blocks;
    byte_rec_t         pending [$];

    function new();
      fill = 0;
      seg_base = 0;
      bit_len = 0;
      rd_ptr = 0;
      errors = 0;
      checked = 0;
      blocks = 0;
    endfunction

    function int stream_bytes();
      return (bit_len + 7) >> 3;
    endfunction

    function int bits_needed(bit [SAMPLE_W-1:0] raw);
      bit [SAMPLE_W-1:0] mag;
      int n;
      if (raw == 0) return 0;
      mag = raw[SAMPLE_W-1] ? ~raw : raw;
      n = 0;
      while (mag != 0) begin
        n++;
        mag >>= 1;
      end
      return n + 1;
    endfunction

    function void emit_bit(bit b);
      if (bit_len < PACK_BYTES * 8 && b) begin
        stream[bit_len >> 3] |= 8'h80 >> (bit_len & 7);
      end
      bit_len++;
    endfunction

    function void emit_segment(ref int remaining);
      int run_len [32];
      int idx, p, width, count, j, k;
      bit cut;
      bit [11:0] hdr;
      idx = seg_base;
      foreach (run_len[i]) run_len[i] = 0;
      p = bits_needed(samples[idx]);
      width = p;
      count = 0;
      forever begin
        count++;
        cut = 0;
        for (j = 0; j < width; j++) begin
          if (p > j) begin
            run_len[j] = 0;
          end else begin
            run_len[j]++;
            if (run_len[j] * (width - j) > 24) begin
              if (run_len[j] < count) count -= run_len[j];
              cut = 1;
              break;
            end
          end
        end
        if (cut || !(count < remaining && count < MAX_RUN)) break;
        p = bits_needed(samples[idx + count]);
        if (p > width) begin
          if (count * (p - width) > 12) break;
          while (width != p) begin
            run_len[width & 31] = count;
            width++;
          end
        end
      end
      hdr = 12'((count << 5) | (width & 31));
      for (j = HDR_BITS - 1; j >= 0; j--) emit_bit(hdr[j]);
      for (k = 0; k < count; k++) begin
        for (j = width - 1; j >= 0; j--) emit_bit(samples[idx + k][j]);
      end
      seg_base += count;
      remaining -= count;
    endfunction

    function void pack_block();
      int remaining;
      remaining = fill;
      foreach (stream[i]) stream[i] = 8'h00;
      bit_len = 0;
      seg_base = 0;
      while (remaining > 0) emit_segment(remaining);
      fill = 0;
      rd_ptr = 0;
      blocks++;
    endfunction

    function void note_input(logic mode, logic [SAMPLE_W-1:0] sample, logic last);
      byte_rec_t rec;
      int size;
      if (mode == MODE_LOAD) begin
        if (fill < STORE_DEPTH) begin
          samples[fill] = sample;
          fill++;
        end
        if (last) pack_block();
      end else begin
        size = stream_bytes();
        if (rd_ptr < size && rd_ptr < PACK_BYTES) begin
          rec.packed_byte = stream[rd_ptr];
          rec.byte_last = (rd_ptr + 1 == size);
          rec.packed_size = SIZE_W'(size);
          pending.push_back(rec);
          rd_ptr++;
        end
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [7:0] b, logic l, logic [SIZE_W-1:0] sz);
      byte_rec_t exp_rec;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected byte %02h", b));
      end else begin
        exp_rec = pending.pop_front();
        if (b !== exp_rec.packed_byte)
          report($sformatf("byte %02h, wanted %02h", b, exp_rec.packed_byte));
        if (l !== exp_rec.byte_last)
          report($sformatf("last flag %b, wanted %b", l, exp_rec.byte_last));
        if (sz !== exp_rec.packed_size)
          report($sformatf("size %0d, wanted %0d", sz, exp_rec.packed_size));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   idle_cycles;
  int   sent;

  awsp_in_if  in_ch ();
  awsp_out_if out_ch ();

  packer_scoreboard sb;

  adaptive_width_segment_packer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.packed_byte, out_ch.byte_last, out_ch.packed_size);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task send(logic mode, logic [SAMPLE_W-1:0] sample, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.sample <= sample;
    in_ch.last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(mode, sample, last);
    sent++;
  endtask

  task hold_off();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task drain();
    hold_off();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic [SAMPLE_W-1:0] sample_of_width(int p);
    logic [SAMPLE_W-1:0] v;
    if (p <= 0) return '0;
    v = SAMPLE_W'($urandom);
    if (p < SAMPLE_W) begin
      v = v & ((SAMPLE_W'(1) << p) - SAMPLE_W'(1));
      if (v[p-1]) v = v | ~((SAMPLE_W'(1) << p) - SAMPLE_W'(1));
    end
    return v;
  endfunction

  task read_all(int extra);
    int n;
    n = sb.stream_bytes() - sb.rd_ptr + extra;
    repeat (n) send(MODE_READ, SAMPLE_W'($urandom), 1'($urandom));
  endtask

  task load_block(int len, int base_w, int spread);
    int w;
    for (int i = 0; i < len; i++) begin
      w = base_w + $urandom_range(0, spread) - spread / 2;
      if (w < 0) w = 0;
      if (w > SAMPLE_W) w = SAMPLE_W;
      send(MODE_LOAD, sample_of_width(w), i == len - 1);
    end
  endtask

  initial begin
    int len;
    sb = new();
    calm = 1'b0;
    idle_cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No block has been packed yet, so these reads give nothing.
    send(MODE_READ, '0, 1'b0);
    send(MODE_READ, '1, 1'b1);
    send(MODE_LOAD, '0, 1'b1);
    read_all(1);
    send(MODE_LOAD, {1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send(MODE_LOAD, {1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    send(MODE_LOAD, '1, 1'b0);
    send(MODE_LOAD, SAMPLE_W'(1), 1'b1);
    read_all(0);
    send(MODE_LOAD, SAMPLE_W'(3), 1'b0);
    send(MODE_READ, '1, 1'b0);
    send(MODE_LOAD, SAMPLE_W'(2), 1'b1);
    read_all(2);
    drain();

    // Overflow: the store fills, later samples are dropped, the flag still packs.
    calm = 1'b1;
    for (int i = 0; i < STORE_DEPTH + 4; i++) begin
      send(MODE_LOAD, '0, i == STORE_DEPTH + 3);
    end
    calm = 1'b0;
    repeat (20) send(MODE_READ, '0, 1'b0);
    drain();

    while (sent < STORE_DEPTH + 1920) begin
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: len = $urandom_range(128, 300);
        1, 2: len = $urandom_range(1, 3);
        default: len = $urandom_range(4, 40);
      endcase
      load_block(len, $urandom_range(0, SAMPLE_W), $urandom_range(0, 8));
      if ($urandom_range(0, 3) == 0) begin
        send(MODE_READ, SAMPLE_W'($urandom), 1'($urandom));
        drain();
      end
      read_all($urandom_range(0, 2));
    end
    drain();
    repeat (40) @(posedge clk);

    $display("Packed %0d blocks from %0d transactions, %0d bytes read back.",
             sb.blocks, sent, sb.checked);
    $display("Covered empty reads, store overflow, reads during load and stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", sb.errors, sb.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: adaptive_width_segment_packer_top.f
hdl/awsp_pkg.sv
hdl/awsp_if.sv
hdl/awsp_ram.sv
hdl/awsp_packer.sv
hdl/adaptive_width_segment_packer_top.sv
bench/tb_top.sv
